// ===== rtl/core/nttbf_pkg.sv =====
// Shared types and constants for the modulo-12289 NTT butterfly lane.
`default_nettype none

package nttbf_pkg;

    // Field widths fixed by the stream format
    localparam int COEF_W      = 14;
    localparam int ADDR_W      = 10;
    localparam int STAGE_W     = 4;
    localparam int TABLE_DEPTH = 1024;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;

    // Modulus in the widths where it is compared
    localparam logic [COEF_W-1:0] MOD_Q14 = 14'd12289;
    localparam logic [COEF_W:0]   MOD_Q15 = 15'd12289;

    // Barrett reduction of a 28-bit product: qest = (x * M) >> 42
    localparam int PROD_W        = 28;
    localparam int QEST_W        = 15;
    localparam int BARRETT_SHIFT = 42;
    localparam int BARRETT_W     = 29;
    localparam int BFULL_W       = PROD_W + BARRETT_W;
    localparam logic [63:0] BARRETT_FULL = (64'd1 << BARRETT_SHIFT) / 64'd12289;
    localparam logic [BARRETT_W-1:0] BARRETT_M = BARRETT_FULL[BARRETT_W-1:0];

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_BFLY = 1'b1
    } mode_t;

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [ADDR_W-1:0] taddr_t;

    // One classified transaction; addr is the write address for a load
    // and the twiddle index for a butterfly
    typedef struct packed {
        mode_t  mode;
        coef_t  even;
        coef_t  odd;
        taddr_t addr;
        coef_t  word;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/nttbf_front.sv =====
// Front end: accepts input transactions, reduces the even value and
// resolves the twiddle index from the pair counter and the stage.
`default_nettype none

module nttbf_front #(
    parameter int TRANSFORM_SIZE   = 1024,
    parameter int LANE_COUNT       = 4,
    parameter int PAIRS_PER_SAMPLE = 128
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic                                s_tuser,
    input  wire logic [nttbf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [nttbf_pkg::STAGE_W-1:0]       stage_number,
    output logic                                     q_push,
    output nttbf_pkg::entry_t                        q_entry,
    input  wire logic                                q_full
);
    import nttbf_pkg::*;

    localparam int CW = (PAIRS_PER_SAMPLE > 1) ? $clog2(PAIRS_PER_SAMPLE) : 1;
    localparam int PW = CW + $clog2(LANE_COUNT) + 1;
    localparam int IW = (PW > ADDR_W) ? PW : ADDR_W;
    localparam logic [4:0] LOGN = 5'($clog2(TRANSFORM_SIZE));

    logic          fv_reg;
    entry_t        entry_reg;
    entry_t        entry_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          accept;
    logic [4:0]    stage_ext;
    logic          stride_sat;
    logic [4:0]    shift_k;
    logic [4:0]    base_e;
    logic [IW-1:0] scaled;
    logic [IW-1:0] quot;
    logic [12:0]   base;
    taddr_t        twiddle_idx;
    coef_t         even_in;

    assign s_tready = !fv_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = fv_reg;
    assign q_entry  = entry_reg;

    // Twiddle index: (cnt * lanes) / stride + N / (2 * stride), stride a power of two
    always_comb begin
        stage_ext   = {1'b0, stage_number};
        stride_sat  = (stage_ext + 5'd1) >= LOGN;
        shift_k     = stride_sat ? 5'd0 : (LOGN - 5'd1 - stage_ext);
        base_e      = stride_sat ? (LOGN - 5'd1) : stage_ext;
        scaled      = IW'(cnt_reg) * IW'(LANE_COUNT);
        quot        = scaled >> shift_k;
        base        = 13'd1 << base_e;
        twiddle_idx = quot[ADDR_W-1:0] + base[ADDR_W-1:0];
    end

    // Classify and build the queue entry
    always_comb begin
        even_in          = s_tdata[13:0];
        entry_next.mode  = mode_t'(s_tuser);
        entry_next.even  = (even_in >= MOD_Q14) ? (even_in - MOD_Q14) : even_in;
        entry_next.odd   = s_tdata[27:14];
        entry_next.addr  = (mode_t'(s_tuser) == MODE_BFLY) ? twiddle_idx : s_tdata[37:28];
        entry_next.word  = s_tdata[51:38];
        cnt_next         = (cnt_reg == CW'(PAIRS_PER_SAMPLE - 1)) ? '0 : (cnt_reg + 1'b1);
    end

    // Control: stage valid and pair counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (s_tready) begin
                fv_reg <= s_tvalid;
            end
            if (accept && mode_t'(s_tuser) == MODE_BFLY) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_reg <= entry_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(PAIRS_PER_SAMPLE - 1))
        else $error("pair counter out of range");
    a_load_keeps_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_t'(s_tuser) == MODE_LOAD) |=> $stable(cnt_reg))
        else $error("load transaction moved the pair counter");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nttbf_queue.sv =====
// Short FIFO that decouples the front end from the butterfly back end.
`default_nettype none

module nttbf_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire nttbf_pkg::entry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output nttbf_pkg::entry_t       head,
    output logic                    empty
);
    import nttbf_pkg::*;

    entry_t              slot_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg;
    logic [QUEUE_AW-1:0] rptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_mem[rptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && do_pop) |=> $stable(count_reg))
        else $error("queue count moved on simultaneous push and pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nttbf_back.sv =====
// Back end: twiddle table, modular multiply pipeline and butterfly output.
`default_nettype none

module nttbf_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire nttbf_pkg::entry_t                head,
    input  wire logic                             empty,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [nttbf_pkg::M_TDATA_W-1:0]       m_tdata
);
    import nttbf_pkg::*;

    logic                   advance;
    coef_t                  twiddle_mem [TABLE_DEPTH];
    coef_t                  tw1_reg;
    coef_t                  even1_reg;
    coef_t                  odd1_reg;
    logic                   v1_reg;
    logic [PROD_W-1:0]      prod2_reg;
    coef_t                  even2_reg;
    logic                   v2_reg;
    logic [BFULL_W-1:0]     bfull;
    logic [QEST_W-1:0]      qest3_reg;
    logic [PROD_W-1:0]      prod3_reg;
    coef_t                  even3_reg;
    logic                   v3_reg;
    logic [PROD_W-1:0]      rem_full;
    logic [COEF_W:0]        rem;
    coef_t                  t_next;
    coef_t                  t4_reg;
    coef_t                  even4_reg;
    logic                   v4_reg;
    logic [COEF_W:0]        sum_raw;
    coef_t                  sum_next;
    coef_t                  diff_next;
    logic                   out_valid_reg;
    coef_t                  sum_reg;
    coef_t                  diff_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign pop      = advance && !empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, diff_reg, sum_reg};

    // Table write for loads, registered twiddle read for butterflies
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (head.mode == MODE_LOAD) begin
                twiddle_mem[head.addr] <= head.word;
            end else begin
                tw1_reg <= twiddle_mem[head.addr];
            end
        end
    end

    // Barrett quotient estimate and remainder correction
    always_comb begin
        bfull    = BFULL_W'(prod2_reg) * BFULL_W'(BARRETT_M);
        rem_full = prod3_reg - (PROD_W'(qest3_reg) * PROD_W'(MOD_Q15));
        rem      = rem_full[COEF_W:0];
        t_next   = (rem >= MOD_Q15) ? COEF_W'(rem - MOD_Q15) : rem[COEF_W-1:0];
    end

    // Butterfly sum and difference
    always_comb begin
        sum_raw   = {1'b0, even4_reg} + {1'b0, t4_reg};
        sum_next  = (sum_raw >= MOD_Q15) ? COEF_W'(sum_raw - MOD_Q15) : sum_raw[COEF_W-1:0];
        diff_next = (even4_reg >= t4_reg) ? (even4_reg - t4_reg)
                                          : (even4_reg + MOD_Q14 - t4_reg);
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= pop && head.mode == MODE_BFLY;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pop) begin
                even1_reg <= head.even;
                odd1_reg  <= head.odd;
            end
            prod2_reg <= PROD_W'(odd1_reg) * PROD_W'(tw1_reg);
            even2_reg <= even1_reg;
            qest3_reg <= bfull[BFULL_W-1:BARRETT_SHIFT];
            prod3_reg <= prod2_reg;
            even3_reg <= even2_reg;
            t4_reg    <= t_next;
            even4_reg <= even3_reg;
            if (v4_reg) begin
                sum_reg  <= sum_next;
                diff_reg <= diff_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(v4_reg) && $stable(v3_reg) && $stable(t4_reg)))
        else $error("pipeline moved while stalled");
    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !pop)
        else $error("queue popped while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ntt_butterfly_mod12289_top.sv =====
// Top level of the modulo-12289 NTT butterfly lane.
//
//  channel  direction  tdata / data                          tuser
//  s_       in         even, odd, table_address, table_word   mode
//  m_       out        sum_out, difference_out                -
//  cfg_     in         stage_number                           -
//
// Sustains one transaction per cycle in either mode while m_tready is high;
// a butterfly passes the front register, queue write, table read, multiply,
// Barrett estimate, correction and output register before m_tvalid rises.
// The 28x29 Barrett multiply stage sets the critical path.
// Reset (synchronous, aresetn low) clears the pair counter, the stage and
// all valids; the twiddle table holds no reset value and must be loaded.
// A stalled m_ side fills the queue, then deasserts s_tready.
// TRANSFORM_SIZE must be a power of two.
`default_nettype none

module ntt_butterfly_mod12289_top #(
    parameter int TRANSFORM_SIZE   = 1024,
    parameter int LANE_COUNT       = 4,
    parameter int PAIRS_PER_SAMPLE = 128
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic                              s_tuser,  // mode
    // even_value, odd_value, table_address, table_word, zero pad
    input  wire logic [nttbf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // sum_out, difference_out, zero pad
    output logic [nttbf_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nttbf_pkg::STAGE_W-1:0]     cfg_data
);
    import nttbf_pkg::*;

    logic [STAGE_W-1:0] stage_reg;
    logic               q_push;
    entry_t             q_entry;
    logic               q_full;
    logic               q_pop;
    entry_t             q_head;
    logic               q_empty;

    assign cfg_ready = 1'b1;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            stage_reg <= cfg_data;
        end
    end

    nttbf_front #(
        .TRANSFORM_SIZE   (TRANSFORM_SIZE),
        .LANE_COUNT       (LANE_COUNT),
        .PAIRS_PER_SAMPLE (PAIRS_PER_SAMPLE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .stage_number (stage_reg),
        .q_push       (q_push),
        .q_entry      (q_entry),
        .q_full       (q_full)
    );

    nttbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    nttbf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the modulo-12289 NTT butterfly lane: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_top;
    import nttbf_pkg::*;

    localparam int TRANSFORM_SIZE   = 1024;
    localparam int LANE_COUNT       = 4;
    localparam int PAIRS_PER_SAMPLE = 128;
    localparam int unsigned Q       = 12289;
    localparam int PHASE_ITEMS      = 90;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 400000;

    typedef struct {
        coef_t sum;
        coef_t diff;
    } bfly_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic                 s_tuser = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [STAGE_W-1:0]   cfg_data = '0;

    // Stimulus and scoreboard storage
    entry_t          pending_pairs[$];
    bfly_result_t    owed_results[$];
    logic [STAGE_W-1:0] stage_writes_q[$];

    // Predictor state, updated on accepted transactions
    coef_t              twiddle_mem [TABLE_DEPTH];
    int unsigned        pair_index = 0;
    logic [STAGE_W-1:0] served_stage = '0;

    // Generator shadow: which entries hold a word, where the counter will be
    bit                 loaded [TABLE_DEPTH];
    int unsigned        gen_pairs = 0;
    logic [STAGE_W-1:0] gen_stage = '0;

    int fail_count   = 0;
    int results_seen = 0;
    int loads_taken  = 0;
    int stage_writes = 0;
    int cycle_count  = 0;

    ntt_butterfly_mod12289_top #(
        .TRANSFORM_SIZE  (TRANSFORM_SIZE),
        .LANE_COUNT      (LANE_COUNT),
        .PAIRS_PER_SAMPLE(PAIRS_PER_SAMPLE)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Twiddle table slot read by a butterfly at the given stage and pair count
    function automatic taddr_t twiddle_slot(input logic [STAGE_W-1:0] stage,
                                            input int unsigned pairs);
        int unsigned stride;
        int unsigned slot;
        stride = TRANSFORM_SIZE >> (int'(stage) + 1);
        if (stride == 0) begin
            stride = 1;
        end
        slot = (pairs * LANE_COUNT) / stride + TRANSFORM_SIZE / (2 * stride);
        return taddr_t'(slot % TABLE_DEPTH);
    endfunction

    // Coefficient with extra weight on the edges and on unreduced values
    function automatic coef_t rand_coef();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return coef_t'(Q - 1);
        end else if (pick == 2) begin
            return coef_t'($urandom_range(Q, 16383));
        end
        return coef_t'($urandom_range(0, Q - 1));
    endfunction

    // Predict the effect of one accepted transaction
    task automatic predict_lane(input entry_t item);
        int unsigned  tw;
        int unsigned  prod;
        int unsigned  ev;
        int unsigned  acc;
        bfly_result_t res;
        if (item.mode == MODE_LOAD) begin
            twiddle_mem[item.addr] = item.word;
            loads_taken++;
            return;
        end
        tw   = 32'(twiddle_mem[twiddle_slot(served_stage, pair_index)]);
        prod = (32'(item.odd) * tw) % Q;
        ev   = 32'(item.even);
        if (ev >= Q) begin
            ev -= Q;
        end
        acc = ev + prod;
        if (acc >= Q) begin
            acc -= Q;
        end
        res.sum  = coef_t'(acc);
        res.diff = coef_t'((ev >= prod) ? ev - prod : ev + Q - prod);
        owed_results.push_back(res);
        pair_index = (pair_index == PAIRS_PER_SAMPLE - 1) ? 0 : pair_index + 1;
    endtask

    task automatic queue_load(input taddr_t where, input coef_t word);
        entry_t item;
        item.mode = MODE_LOAD;
        item.even = coef_t'($urandom);
        item.odd  = coef_t'($urandom);
        item.addr = where;
        item.word = word;
        loaded[where] = 1'b1;
        pending_pairs.push_back(item);
    endtask

    // Queue a butterfly, loading its twiddle first if that entry is still empty
    task automatic queue_bfly(input coef_t even, input coef_t odd);
        entry_t item;
        taddr_t slot;
        slot = twiddle_slot(gen_stage, gen_pairs);
        if (!loaded[slot]) begin
            queue_load(slot, rand_coef());
        end
        item.mode = MODE_BFLY;
        item.even = even;
        item.odd  = odd;
        item.addr = taddr_t'($urandom);
        item.word = coef_t'($urandom);
        pending_pairs.push_back(item);
        gen_pairs = (gen_pairs == PAIRS_PER_SAMPLE - 1) ? 0 : gen_pairs + 1;
    endtask

    // Wait for the lane to go idle, then give in-flight loads time to land
    task automatic settle();
        while (pending_pairs.size() != 0 || s_tvalid || owed_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stage(input logic [STAGE_W-1:0] stage);
        int target;
        target = stage_writes + 1;
        gen_stage = stage;
        stage_writes_q.push_back(stage);
        while (stage_writes != target) begin
            @(posedge aclk);
        end
    endtask

    // Input stream driver: bursts of transactions separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;
    always @(posedge aclk) begin : drive_inputs
        bit     next_valid;
        entry_t head;
        if (gap_left != 0) begin
            gap_left--;
        end
        if (s_tvalid && s_tready) begin
            predict_lane(pending_pairs.pop_front());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 32);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        next_valid = aresetn && gap_left == 0 && pending_pairs.size() != 0;
        if (next_valid) begin
            head = pending_pairs[0];
            s_tdata <= {4'b0, head.word, head.addr, head.odd, head.even};
            s_tuser <= head.mode;
        end
        s_tvalid <= next_valid;
    end

    // Stage register write channel
    always @(posedge aclk) begin : drive_config
        bit next_valid;
        next_valid = 1'b0;
        if (cfg_valid && cfg_ready) begin
            served_stage = cfg_data;
            stage_writes++;
        end else if (cfg_valid) begin
            next_valid = 1'b1;
        end
        if (!next_valid && aresetn && stage_writes_q.size() != 0) begin
            next_valid = 1'b1;
            cfg_data <= stage_writes_q.pop_front();
        end
        cfg_valid <= next_valid;
    end

    // Result monitor and backpressure pattern
    int stall_kind = 0;
    int stall_span = 0;
    int hold_left  = 0;
    always @(posedge aclk) begin : check_results
        bfly_result_t want;
        coef_t        got_sum;
        coef_t        got_diff;
        bit           next_ready;
        if (aresetn && m_tvalid && m_tready) begin
            got_sum  = m_tdata[COEF_W-1:0];
            got_diff = m_tdata[2*COEF_W-1:COEF_W];
            if (owed_results.size() == 0) begin
                $error("unexpected result: sum_out=%0d difference_out=%0d", got_sum, got_diff);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                results_seen++;
                if (got_sum !== want.sum) begin
                    $error("sum_out: expected %0d, got %0d", want.sum, got_sum);
                    fail_count++;
                end
                if (got_diff !== want.diff) begin
                    $error("difference_out: expected %0d, got %0d", want.diff, got_diff);
                    fail_count++;
                end
            end
        end
        if (stall_span == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 200);
        end
        stall_span--;
        next_ready = m_tready;
        if (hold_left != 0) begin
            hold_left--;
        end else begin
            case (stall_kind)
                0: begin
                    next_ready = 1'b1;
                end
                1: begin
                    next_ready = 1'($urandom_range(0, 1));
                end
                2: begin
                    next_ready = ($urandom_range(0, 3) == 0);
                end
                default: begin
                    next_ready = !m_tready;
                    hold_left  = $urandom_range(1, 20);
                end
            endcase
        end
        m_tready <= next_ready;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ntt_butterfly_mod12289_top: mismatch");
            $finish;
        end
    end

    // Test sequence
    logic [STAGE_W-1:0] stage_plan [13] = '{4'd0, 4'd11, 4'd9, 4'd1, 4'd10, 4'd15, 4'd4,
                                           4'd7, 4'd8, 4'd2, 4'd3, 4'd5, 4'd6};
    initial begin
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: stage 0 always reads twiddle slot 1
        write_stage(4'd0);
        queue_load(10'd1, 14'd0);
        queue_bfly(14'd0, 14'd0);
        queue_bfly(14'd12288, 14'd16383);
        queue_bfly(14'd16383, 14'd12288);
        queue_load(10'd1, 14'd1);
        queue_bfly(14'd0, 14'd12288);        // difference wraps below zero
        queue_bfly(14'd12288, 14'd12288);    // sum wraps past the modulus
        queue_bfly(14'd16383, 14'd16383);    // unreduced even and odd
        queue_load(10'd1, 14'd16383);        // unreduced twiddle
        queue_bfly(14'd1, 14'd16383);
        queue_bfly(14'd12289, 14'd1);
        queue_load(10'd0, 14'd16383);
        queue_load(10'd1023, 14'd0);
        queue_load(10'd1, 14'd12288);
        queue_bfly(14'd5, 14'd12288);
        queue_bfly(14'd12288, 14'd0);
        settle();

        // Random phases, one stage setting each
        foreach (stage_plan[p]) begin
            write_stage(stage_plan[p]);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    queue_load(taddr_t'($urandom_range(0, TABLE_DEPTH - 1)), rand_coef());
                end else if (pick < 28) begin
                    // rewrite the entry the next butterfly reads, right before it
                    queue_load(twiddle_slot(gen_stage, gen_pairs), rand_coef());
                    queue_bfly(rand_coef(), rand_coef());
                end else begin
                    queue_bfly(rand_coef(), rand_coef());
                end
            end
            settle();
        end

        $display("run covered %0d butterfly results and %0d twiddle loads", results_seen,
                 loads_taken);
        $display("over %0d stage settings, with random bursts and output stalls",
                 stage_writes);
        if (fail_count == 0) begin
            $display("ntt_butterfly_mod12289_top: match");
        end else begin
            $display("ntt_butterfly_mod12289_top: mismatch");
        end
        $finish;
    end

endmodule
